// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ===== rtl/psfp_pkg.sv =====
// Package for the particle sensor frame parser: constants, status codes, queue entry.
// No dependencies.
`timescale 1ns / 1ps
package psfp_pkg;
  localparam int POS_W = 4;
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] CMD_BYTE = 8'h86;
  localparam logic [POS_W-1:0] LAST_POS = 4'd8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_HEADER   = 2'd1,
    ST_BAD_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } q_entry_t;
endpackage

// ===== rtl/psfp_rx_if.sv =====
// Byte input channel: valid/ready with the received byte and restart flag.
// No dependencies.
`timescale 1ns / 1ps
interface psfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

// ===== rtl/psfp_res_if.sv =====
// Result channel: valid/ready with three readings and the frame status.
// No dependencies.
`timescale 1ns / 1ps
interface psfp_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] fine_reading;
  logic [15:0] mid_reading;
  logic [15:0] coarse_reading;
  logic [1:0]  frame_status;

  modport source (output valid, output fine_reading, output mid_reading,
                  output coarse_reading, output frame_status, input ready);
  modport sink (input valid, input fine_reading, input mid_reading,
                input coarse_reading, input frame_status, output ready);
endinterface

// ===== rtl/psfp_front.sv =====
// Front end: accepts bytes and tags each with its frame position.
// Depends on psfp_pkg and psfp_rx_if.
`timescale 1ns / 1ps
module psfp_front (
  input  logic               clk,
  input  logic               rst,
  psfp_rx_if.sink            rx_ch,
  input  logic               q_full,
  output logic               push,
  output psfp_pkg::q_entry_t push_entry
);
  import psfp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] cur_pos;

  assign rx_ch.ready = !q_full;
  assign push = rx_ch.valid && rx_ch.ready;

  always_comb begin
    cur_pos = (rx_ch.restart || pos > LAST_POS) ? '0 : pos;
    pos_next = (cur_pos >= LAST_POS) ? '0 : cur_pos + 1'b1;
    push_entry.data = rx_ch.rx_byte;
    push_entry.pos = cur_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      pos <= pos_next;
    end
  end
endmodule

// ===== rtl/psfp_queue.sv =====
// Small FIFO between the byte front end and the frame assembler.
// Depends on psfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psfp_queue #(
  parameter int DEPTH = psfp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  psfp_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output psfp_pkg::q_entry_t head
);
  import psfp_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK_RST(a_no_push_full, clk, rst, push |-> !full, "push into full queue")
  `ASSERT_CLK_RST(a_no_pop_empty, clk, rst, pop |-> head_valid, "pop from empty queue")
  `ASSERT_CLK_RST(a_count_range, clk, rst, count <= CNT_W'(DEPTH), "queue count overflow")
  `ASSERT_CLK_RST(a_count_step, clk, rst, (push && !pop) |=> count == $past(count) + 1'b1,
                  "queue count did not grow on push")
endmodule

// ===== rtl/psfp_back.sv =====
// Back end: assembles readings, checks header and checksum, holds the result.
// Depends on psfp_pkg, psfp_res_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psfp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  psfp_pkg::q_entry_t head,
  output logic               pop,
  psfp_res_if.source         res_ch
);
  import psfp_pkg::*;

  logic [7:0]  running_sum;
  logic        header_bad;
  logic [15:0] mid_value;
  logic [15:0] coarse_value;
  logic [7:0]  fine_high;
  logic [7:0]  fine_low;

  logic        res_valid;
  logic [15:0] fine_q;
  logic [15:0] mid_q;
  logic [15:0] coarse_q;
  status_t     status_q;

  logic        is_last;
  logic        load;
  logic [7:0]  expect_sum;
  status_t     status_next;

  assign is_last = (head.pos == LAST_POS);
  assign pop = head_valid && (!is_last || !res_valid || res_ch.ready);
  assign load = pop && is_last;
  assign expect_sum = 8'd0 - running_sum;

  always_comb begin
    if (header_bad) begin
      status_next = ST_BAD_HEADER;
    end else if (expect_sum != head.data) begin
      status_next = ST_BAD_CHECKSUM;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      header_bad <= 1'b0;
    end else if (pop) begin
      case (head.pos)
        4'd0: begin
          running_sum <= '0;
          header_bad <= (head.data != START_BYTE);
        end
        4'd1: begin
          running_sum <= running_sum + head.data;
          if (head.data != CMD_BYTE) begin
            header_bad <= 1'b1;
          end
        end
        4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
          running_sum <= running_sum + head.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.pos)
        4'd2: mid_value[15:8] <= head.data;
        4'd3: mid_value[7:0] <= head.data;
        4'd4: coarse_value[15:8] <= head.data;
        4'd5: coarse_value[7:0] <= head.data;
        4'd6: fine_high <= head.data;
        4'd7: fine_low <= head.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_q <= status_next;
      if (status_next == ST_OK) begin
        fine_q <= {fine_high, fine_low};
        mid_q <= mid_value;
        coarse_q <= coarse_value;
      end else begin
        fine_q <= '0;
        mid_q <= '0;
        coarse_q <= '0;
      end
    end
  end

  assign res_ch.valid = res_valid;
  assign res_ch.fine_reading = fine_q;
  assign res_ch.mid_reading = mid_q;
  assign res_ch.coarse_reading = coarse_q;
  assign res_ch.frame_status = status_q;

  `ASSERT_CLK_RST(a_load_room, clk, rst, load |-> (!res_valid || res_ch.ready),
                  "result overwritten before transfer")
  `ASSERT_CLK_RST(a_rise_from_last, clk, rst, $rose(res_valid) |-> $past(load),
                  "result raised without a final byte")
  `ASSERT_CLK_RST(a_fail_zero, clk, rst,
                  (res_valid && status_q != ST_OK) |->
                  (fine_q == '0 && mid_q == '0 && coarse_q == '0),
                  "failed frame carries nonzero readings")
endmodule

// ===== rtl/particle_sensor_frame_parser_unit.sv =====
// The ninth byte is registered in the queue, then its result in res_valid.
// Throughput: one byte per cycle, set by the single-entry-per-cycle queue pop,
// whenever no result stalls. A stalled result holds the back end only on a frame's
// last byte; the queue then fills to QUEUE_DEPTH bytes, the stalled one included,
// before input ready drops.
// Reset (rst, synchronous): clears frame position, queue and result valid.
`timescale 1ns / 1ps
module particle_sensor_frame_parser_unit #(
  parameter int QUEUE_DEPTH = psfp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  psfp_rx_if.sink    rx_ch,
  psfp_res_if.source res_ch
);
  import psfp_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     pop;
  logic     head_valid;
  q_entry_t head;

  psfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_ch      (rx_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  psfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  psfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_ch     (res_ch)
  );
endmodule
